// ===== design/afrk_pkg.sv =====
package afrk_pkg;

  localparam int M_W    = 4;
  localparam int DT_W   = 17;
  localparam int DT_FRAC = 16;

  localparam logic [M_W-1:0]  MAG_RST = 4'd1;
  localparam logic [DT_W-1:0] DT_RST  = 17'd6554;

  typedef enum logic {
    REG_MAG = 1'b0,
    REG_DT  = 1'b1
  } reg_idx_t;

endpackage

// ===== design/afrk_if.sv =====
interface afrk_in_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] pos_x;
  logic signed [W-1:0] pos_y;
  logic signed [W-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface afrk_out_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] new_x;
  logic signed [W-1:0] new_y;
  logic signed [W-1:0] new_z;

  modport source (output valid, new_x, new_y, new_z, input ready);
  modport sink (input valid, new_x, new_y, new_z, output ready);
endinterface

// ===== design/azimuthal_flow_rk4_step.sv =====
// Most of the pipeline is made up of four velocity evaluations, each with one
// quotient bit per stage.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: synchronous, clears all valid bits; magnetic_number = 1, time_step = 6554.
module azimuthal_flow_rk4_step #(
  parameter int FRAC_BITS = 16,
  parameter int POS_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  afrk_in_if.sink     pos_in,
  afrk_out_if.source  pos_out
);
  import afrk_pkg::*;

  localparam int W   = POS_WIDTH;
  localparam int AW  = W + 3;
  localparam int SBW = 3 * W + 2 * AW;

  logic [M_W-1:0]  mag;
  logic [DT_W-1:0] dt;
  logic            en;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag <= MAG_RST;
      dt  <= DT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_MAG: mag <= pwdata[M_W-1:0];
        REG_DT:  dt  <= pwdata[DT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_MAG: prdata = 32'(mag);
      REG_DT:  prdata = 32'(dt);
      default: prdata = '0;
    endcase
  end

  // sideband: {x, y, z, acc_x, acc_y}
  function automatic logic [SBW-1:0] sb_pack(input logic [SBW-1:0] sb,
                                             input logic [AW-1:0] ax,
                                             input logic [AW-1:0] ay);
    return {sb[SBW-1:2*AW], ax, ay};
  endfunction

  logic                v1_v, a1_v, v2_v, a2_v, v3_v, a3_v, v4_v, af_v;
  logic signed [W-1:0] k1x, k1y, k2x, k2y, k3x, k3y, k4x, k4y;
  logic signed [W-1:0] p2x, p2y, p3x, p3y, p4x, p4y, nx, ny;
  logic [SBW-1:0]      v1_sb, a1_sb, v2_sb, a2_sb, v3_sb, a3_sb, v4_sb, af_sb;
  logic [SBW-1:0]      sb0, a1_sbi, a2_sbi, a3_sbi;
  logic signed [AW-1:0] acc_x, acc_y;

  assign en = !pos_out.valid || pos_out.ready;
  assign pos_in.ready = en;
  assign sb0 = {pos_in.pos_x, pos_in.pos_y, pos_in.pos_z, {(2*AW){1'b0}}};

  afrk_vel #(.W(W), .F(FRAC_BITS), .SBW(SBW)) u_vel1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(pos_in.valid),
    .px(pos_in.pos_x), .py(pos_in.pos_y), .m(mag), .sb_in(sb0),
    .out_valid(v1_v), .vx(k1x), .vy(k1y), .sb_out(v1_sb)
  );

  assign a1_sbi = sb_pack(v1_sb, AW'(k1x), AW'(k1y));

  afrk_adv #(.W(W), .KW(W), .SH(DT_FRAC + 1), .DIV6(0), .SBW(SBW)) u_adv1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1_v),
    .bx(v1_sb[SBW-1 -: W]), .by(v1_sb[SBW-1-W -: W]), .kx(k1x), .ky(k1y), .dt(dt),
    .sb_in(a1_sbi), .out_valid(a1_v), .ox(p2x), .oy(p2y), .sb_out(a1_sb)
  );

  afrk_vel #(.W(W), .F(FRAC_BITS), .SBW(SBW)) u_vel2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(a1_v),
    .px(p2x), .py(p2y), .m(mag), .sb_in(a1_sb),
    .out_valid(v2_v), .vx(k2x), .vy(k2y), .sb_out(v2_sb)
  );

  assign a2_sbi = sb_pack(v2_sb,
                          AW'($signed(v2_sb[2*AW-1 -: AW]) + (AW'(k2x) <<< 1)),
                          AW'($signed(v2_sb[AW-1:0]) + (AW'(k2y) <<< 1)));

  afrk_adv #(.W(W), .KW(W), .SH(DT_FRAC + 1), .DIV6(0), .SBW(SBW)) u_adv2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2_v),
    .bx(v2_sb[SBW-1 -: W]), .by(v2_sb[SBW-1-W -: W]), .kx(k2x), .ky(k2y), .dt(dt),
    .sb_in(a2_sbi), .out_valid(a2_v), .ox(p3x), .oy(p3y), .sb_out(a2_sb)
  );

  afrk_vel #(.W(W), .F(FRAC_BITS), .SBW(SBW)) u_vel3 (
    .clk(clk), .rst(rst), .en(en), .in_valid(a2_v),
    .px(p3x), .py(p3y), .m(mag), .sb_in(a2_sb),
    .out_valid(v3_v), .vx(k3x), .vy(k3y), .sb_out(v3_sb)
  );

  assign a3_sbi = sb_pack(v3_sb,
                          AW'($signed(v3_sb[2*AW-1 -: AW]) + (AW'(k3x) <<< 1)),
                          AW'($signed(v3_sb[AW-1:0]) + (AW'(k3y) <<< 1)));

  afrk_adv #(.W(W), .KW(W), .SH(DT_FRAC), .DIV6(0), .SBW(SBW)) u_adv3 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3_v),
    .bx(v3_sb[SBW-1 -: W]), .by(v3_sb[SBW-1-W -: W]), .kx(k3x), .ky(k3y), .dt(dt),
    .sb_in(a3_sbi), .out_valid(a3_v), .ox(p4x), .oy(p4y), .sb_out(a3_sb)
  );

  afrk_vel #(.W(W), .F(FRAC_BITS), .SBW(SBW)) u_vel4 (
    .clk(clk), .rst(rst), .en(en), .in_valid(a3_v),
    .px(p4x), .py(p4y), .m(mag), .sb_in(a3_sb),
    .out_valid(v4_v), .vx(k4x), .vy(k4y), .sb_out(v4_sb)
  );

  // weighted sum k1 + 2k2 + 2k3 + k4, then times dt/6
  assign acc_x = AW'($signed(v4_sb[2*AW-1 -: AW]) + AW'(k4x));
  assign acc_y = AW'($signed(v4_sb[AW-1:0]) + AW'(k4y));

  afrk_adv #(.W(W), .KW(AW), .SH(DT_FRAC), .DIV6(1), .SBW(SBW)) u_advf (
    .clk(clk), .rst(rst), .en(en), .in_valid(v4_v),
    .bx(v4_sb[SBW-1 -: W]), .by(v4_sb[SBW-1-W -: W]), .kx(acc_x), .ky(acc_y), .dt(dt),
    .sb_in(v4_sb), .out_valid(af_v), .ox(nx), .oy(ny), .sb_out(af_sb)
  );

  assign pos_out.valid = af_v;
  assign pos_out.new_x = nx;
  assign pos_out.new_y = ny;
  assign pos_out.new_z = af_sb[SBW-1-2*W -: W];

endmodule

// ===== design/afrk_vel.sv =====
module afrk_vel #(
  parameter int W   = 32,
  parameter int F   = 16,
  parameter int SBW = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [W-1:0]        px,
  input  logic signed [W-1:0]        py,
  input  logic [afrk_pkg::M_W-1:0]   m,
  input  logic [SBW-1:0]             sb_in,
  output logic                       out_valid,
  output logic signed [W-1:0]        vx,
  output logic signed [W-1:0]        vy,
  output logic [SBW-1:0]             sb_out
);
  import afrk_pkg::*;

  localparam int H   = (W + 1) / 2;
  localparam int HW  = W - H;
  localparam int MW  = W + 3;
  localparam int NW  = MW + 2 * F;
  localparam int DW  = 2 * W;
  localparam int RW  = 2 * W + 1;
  localparam int R0W = NW - (W + 1);
  localparam int CW  = (R0W > DW) ? R0W : DW;
  localparam logic [DW-1:0] AXIS_R2 = DW'((64'd1 << (2 * F)) / 64'd100000000);
  localparam logic [W:0]    LIMQ = {2'b01, {(W-1){1'b0}}};
  localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic           v;
    logic [SBW-1:0] sb;
    logic [DW-1:0]  r2;
    logic           axis;
    logic           negx;
    logic           negy;
    logic           ovfx;
    logic           ovfy;
    logic [W:0]     nlox;
    logic [W:0]     nloy;
    logic [RW-1:0]  remx;
    logic [RW-1:0]  remy;
    logic [W:0]     qx;
    logic [W:0]     qy;
  } div_t;

  // stage 1: partial products of the squares, m times coordinate
  logic           s1_v;
  logic [SBW-1:0] s1_sb;
  logic [2*HW-1:0] xhh, yhh;
  logic [HW+H-1:0] xhl, yhl;
  logic [2*H-1:0]  xll, yll;
  logic signed [W+3:0] s1_mx, s1_my;

  logic [W-1:0] ax, ay;
  assign ax = px[W-1] ? W'(-px) : W'(px);
  assign ay = py[W-1] ? W'(-py) : W'(py);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v  <= in_valid;
      s1_sb <= sb_in;
      xhh   <= (2*HW)'(ax[W-1:H]) * (2*HW)'(ax[W-1:H]);
      xhl   <= (HW+H)'(ax[W-1:H]) * (HW+H)'(ax[H-1:0]);
      xll   <= (2*H)'(ax[H-1:0]) * (2*H)'(ax[H-1:0]);
      yhh   <= (2*HW)'(ay[W-1:H]) * (2*HW)'(ay[W-1:H]);
      yhl   <= (HW+H)'(ay[W-1:H]) * (HW+H)'(ay[H-1:0]);
      yll   <= (2*H)'(ay[H-1:0]) * (2*H)'(ay[H-1:0]);
      s1_mx <= (W+4)'($signed(m)) * (W+4)'(px);
      s1_my <= (W+4)'($signed(m)) * (W+4)'(py);
    end
  end

  // stage 2: assemble squares
  logic           s2_v;
  logic [SBW-1:0] s2_sb;
  logic [DW-1:0]  sqx, sqy;
  logic signed [W+3:0] s2_mx, s2_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v  <= s1_v;
      s2_sb <= s1_sb;
      sqx   <= (DW'(xhh) << (2 * H)) + (DW'(xhl) << (H + 1)) + DW'(xll);
      sqy   <= (DW'(yhh) << (2 * H)) + (DW'(yhl) << (H + 1)) + DW'(yll);
      s2_mx <= s1_mx;
      s2_my <= s1_my;
    end
  end

  // stage 3: r^2, axis cut, numerator magnitudes and signs
  logic           s3_v;
  logic [SBW-1:0] s3_sb;
  logic [DW-1:0]  s3_r2;
  logic           s3_axis;
  logic [MW-1:0]  magx, magy;
  logic           s3_negx, s3_negy;
  logic [DW-1:0]  r2_sum;
  logic [W+3:0]   abs_my, abs_mx;

  assign r2_sum = sqx + sqy;
  assign abs_my = s2_my[W+3] ? (W+4)'(-s2_my) : (W+4)'(s2_my);
  assign abs_mx = s2_mx[W+3] ? (W+4)'(-s2_mx) : (W+4)'(s2_mx);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v    <= s2_v;
      s3_sb   <= s2_sb;
      s3_r2   <= r2_sum;
      s3_axis <= (r2_sum <= AXIS_R2);
      magx    <= abs_my[MW-1:0];
      magy    <= abs_mx[MW-1:0];
      // vx numerator is -(m*y)
      s3_negx <= (s2_my > 0);
      s3_negy <= s2_mx[W+3];
    end
  end

  // stage 4: overflow precheck, division setup
  div_t dstg [0:W+1];
  div_t d0;
  logic [NW-1:0]  nx_full, ny_full;
  logic [R0W-1:0] r0x, r0y;

  always_comb begin
    nx_full    = {magx, {(2*F){1'b0}}};
    ny_full    = {magy, {(2*F){1'b0}}};
    r0x        = nx_full[NW-1:W+1];
    r0y        = ny_full[NW-1:W+1];
    d0.v       = s3_v;
    d0.sb      = s3_sb;
    d0.r2      = s3_r2;
    d0.axis    = s3_axis;
    d0.negx    = s3_negx;
    d0.negy    = s3_negy;
    d0.ovfx    = (CW'(r0x) >= CW'(s3_r2));
    d0.ovfy    = (CW'(r0y) >= CW'(s3_r2));
    d0.nlox    = nx_full[W:0];
    d0.nloy    = ny_full[W:0];
    d0.remx    = RW'(r0x);
    d0.remy    = RW'(r0y);
    d0.qx      = '0;
    d0.qy      = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstg[0].v <= 1'b0;
    end else if (en) begin
      dstg[0] <= d0;
    end
  end

  // one restoring quotient bit per stage
  for (genvar j = 0; j <= W; j++) begin : g_div
    div_t dn;
    always_comb begin
      logic [RW-1:0] tx, ty;
      dn = dstg[j];
      tx = {dstg[j].remx[RW-2:0], dstg[j].nlox[W-j]};
      ty = {dstg[j].remy[RW-2:0], dstg[j].nloy[W-j]};
      if (tx >= RW'(dstg[j].r2)) begin
        dn.remx      = tx - RW'(dstg[j].r2);
        dn.qx[W-j]   = 1'b1;
      end else begin
        dn.remx      = tx;
      end
      if (ty >= RW'(dstg[j].r2)) begin
        dn.remy      = ty - RW'(dstg[j].r2);
        dn.qy[W-j]   = 1'b1;
      end else begin
        dn.remy      = ty;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dstg[j+1].v <= 1'b0;
      end else if (en) begin
        dstg[j+1] <= dn;
      end
    end
  end

  function automatic logic [W-1:0] vsat(input logic [W:0] q, input logic neg,
                                        input logic ovf, input logic axis);
    logic [W-1:0] r;
    if (axis) begin
      r = '0;
    end else if (neg) begin
      r = (ovf || q > LIMQ) ? MINV : W'(-q);
    end else begin
      r = (ovf || q >= LIMQ) ? MAXV : W'(q);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dstg[W+1].v;
      sb_out    <= dstg[W+1].sb;
      vx        <= vsat(dstg[W+1].qx, dstg[W+1].negx, dstg[W+1].ovfx, dstg[W+1].axis);
      vy        <= vsat(dstg[W+1].qy, dstg[W+1].negy, dstg[W+1].ovfy, dstg[W+1].axis);
    end
  end

endmodule

// ===== design/afrk_adv.sv =====
module afrk_adv #(
  parameter int W    = 32,
  parameter int KW   = 32,
  parameter int SH   = 17,
  parameter int DIV6 = 0,
  parameter int SBW  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [W-1:0]         bx,
  input  logic signed [W-1:0]         by,
  input  logic signed [KW-1:0]        kx,
  input  logic signed [KW-1:0]        ky,
  input  logic [afrk_pkg::DT_W-1:0]   dt,
  input  logic [SBW-1:0]              sb_in,
  output logic                        out_valid,
  output logic signed [W-1:0]         ox,
  output logic signed [W-1:0]         oy,
  output logic [SBW-1:0]              sb_out
);
  import afrk_pkg::*;

  localparam int PRW = KW + DT_W;
  localparam int SHT = SH + DIV6;
  localparam int PW  = PRW - SHT;
  localparam int ND  = (DIV6 != 0) ? (PW + 7) / 8 : 0;
  localparam int SW  = PW + 2;
  localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMIN = SW'(-(64'sd1 <<< (W - 1)));

  typedef struct packed {
    logic           v;
    logic [SBW-1:0] sb;
    logic [W-1:0]   bx;
    logic [W-1:0]   by;
    logic           negx;
    logic           negy;
    logic [PW-1:0]  qx;
    logic [PW-1:0]  qy;
    logic [1:0]     rx;
    logic [1:0]     ry;
  } adv_t;

  adv_t cst [0:ND];
  adv_t c0;
  logic [KW-1:0]  mkx, mky;
  logic [PRW-1:0] prx, pry;

  // stage 1: |k| * dt, fixed shift
  always_comb begin
    mkx     = kx[KW-1] ? KW'(-kx) : KW'(kx);
    mky     = ky[KW-1] ? KW'(-ky) : KW'(ky);
    prx     = PRW'(mkx) * PRW'(dt);
    pry     = PRW'(mky) * PRW'(dt);
    c0.v    = in_valid;
    c0.sb   = sb_in;
    c0.bx   = bx;
    c0.by   = by;
    c0.negx = kx[KW-1];
    c0.negy = ky[KW-1];
    c0.qx   = prx[PRW-1:SHT];
    c0.qy   = pry[PRW-1:SHT];
    c0.rx   = '0;
    c0.ry   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst[0].v <= 1'b0;
    end else if (en) begin
      cst[0] <= c0;
    end
  end

  // divide by three, eight quotient bits per stage, MSB first, in place
  for (genvar s = 0; s < ND; s++) begin : g_div3
    adv_t cn;
    always_comb begin
      logic [2:0] tx, ty;
      cn = cst[s];
      for (int i = PW - 1; i >= 0; i--) begin
        if (i <= PW - 1 - 8 * s && i > PW - 1 - 8 * (s + 1)) begin
          tx = {cn.rx, cn.qx[i]};
          ty = {cn.ry, cn.qy[i]};
          if (tx >= 3'd3) begin
            tx        = tx - 3'd3;
            cn.qx[i]  = 1'b1;
          end else begin
            cn.qx[i]  = 1'b0;
          end
          if (ty >= 3'd3) begin
            ty        = ty - 3'd3;
            cn.qy[i]  = 1'b1;
          end else begin
            cn.qy[i]  = 1'b0;
          end
          cn.rx = tx[1:0];
          cn.ry = ty[1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cst[s+1].v <= 1'b0;
      end else if (en) begin
        cst[s+1] <= cn;
      end
    end
  end

  function automatic logic [W-1:0] addsat(input logic [W-1:0] b, input logic [PW-1:0] q,
                                          input logic neg);
    logic signed [SW-1:0] d, sum, r;
    d   = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sum = SW'($signed(b)) + d;
    if (sum < SMIN) begin
      r = SMIN;
    end else if (sum > SMAX) begin
      r = SMAX;
    end else begin
      r = sum;
    end
    return r[W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cst[ND].v;
      sb_out    <= cst[ND].sb;
      ox        <= addsat(cst[ND].bx, cst[ND].qx, cst[ND].negx);
      oy        <= addsat(cst[ND].by, cst[ND].qy, cst[ND].negy);
    end
  end

endmodule

// ===== design/afrk_chk.sv =====
module afrk_chk #(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] new_x,
  input logic [W-1:0] new_y,
  input logic [W-1:0] new_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(new_x) && $stable(new_y) && $stable(new_z))
    else $error("stalled output item changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind azimuthal_flow_rk4_step afrk_chk #(.W(POS_WIDTH)) u_chk (
  .clk(clk), .rst(rst),
  .in_valid(pos_in.valid), .in_ready(pos_in.ready),
  .out_valid(pos_out.valid), .out_ready(pos_out.ready),
  .new_x(pos_out.new_x), .new_y(pos_out.new_y), .new_z(pos_out.new_z)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import afrk_pkg::*;

  localparam longint POS_MAX     = 64'sd2147483647;
  localparam longint POS_MIN     = -64'sd2147483648;
  localparam int     AXIS_R2_LIM = 42;      // 2^32 / 1e8, truncated
  localparam int     DRAIN_WAIT  = 200;     // longer than the pipeline is deep
  localparam int     CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  afrk_in_if  #(.W(32)) pos_in ();
  afrk_out_if #(.W(32)) pos_out ();

  azimuthal_flow_rk4_step dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pos_in(pos_in), .pos_out(pos_out)
  );

  // predictor copy of the registers
  logic signed [3:0] mag_num;
  logic [16:0]       step_dt;

  pos_t   expected_pos[$];
  int     mismatches;
  int     cycles;
  int     stall_left;
  bit     send_free;
  bit     recv_free;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint abs_val(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat_pos(longint v);
    if (v < POS_MIN) return POS_MIN;
    if (v > POS_MAX) return POS_MAX;
    return v;
  endfunction

  function automatic longint vel_comp(longint num, logic [127:0] r2);
    logic [127:0] q;
    q = (128'(abs_val(num)) << 32) / r2;
    if (num < 0) begin
      if (q > 128'd2147483648) return POS_MIN;
      return -longint'(q[63:0]);
    end
    if (q > 128'd2147483647) return POS_MAX;
    return longint'(q[63:0]);
  endfunction

  function automatic void flow_velocity(input longint x, input longint y, input longint m,
                                        output longint vx, output longint vy);
    logic [127:0] r2;
    r2 = 128'(abs_val(x)) * 128'(abs_val(x)) + 128'(abs_val(y)) * 128'(abs_val(y));
    if (r2 <= AXIS_R2_LIM) begin
      vx = 0;
      vy = 0;
    end else begin
      vx = vel_comp(-(m * y), r2);
      vy = vel_comp(m * x, r2);
    end
  endfunction

  function automatic longint dt_scale(longint k, logic [16:0] dt, longint div);
    logic [127:0] q;
    q = (128'(abs_val(k)) * 128'(dt)) / 128'(div);
    return k < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic pos_t rk4_advance(logic signed [31:0] px, logic signed [31:0] py,
                                       logic signed [31:0] pz);
    longint x, y, m, ax, ay, bx, by, cx, cy, dx, dy, sx, sy;
    pos_t r;
    x = px;
    y = py;
    m = mag_num;
    flow_velocity(x, y, m, ax, ay);
    flow_velocity(sat_pos(x + dt_scale(ax, step_dt, 1 << 17)),
                  sat_pos(y + dt_scale(ay, step_dt, 1 << 17)), m, bx, by);
    flow_velocity(sat_pos(x + dt_scale(bx, step_dt, 1 << 17)),
                  sat_pos(y + dt_scale(by, step_dt, 1 << 17)), m, cx, cy);
    flow_velocity(sat_pos(x + dt_scale(cx, step_dt, 1 << 16)),
                  sat_pos(y + dt_scale(cy, step_dt, 1 << 16)), m, dx, dy);
    sx = ax + 2 * bx + 2 * cx + dx;
    sy = ay + 2 * by + 2 * cy + dy;
    r.x = 32'(sat_pos(x + dt_scale(sx, step_dt, 6 * (1 << 16))));
    r.y = 32'(sat_pos(y + dt_scale(sy, step_dt, 6 * (1 << 16))));
    r.z = pz;
    return r;
  endfunction

  // predict on input accept, compare on output accept
  always @(posedge clk) begin
    pos_t got, want;
    if (!rst) begin
      if (pos_in.valid && pos_in.ready)
        expected_pos.insert(expected_pos.size(),
                            rk4_advance(pos_in.pos_x, pos_in.pos_y, pos_in.pos_z));
      if (pos_out.valid && pos_out.ready) begin
        got.x = pos_out.new_x;
        got.y = pos_out.new_y;
        got.z = pos_out.new_z;
        if (expected_pos.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        end else begin
          want = expected_pos.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                       want.x, want.y, want.z, got.x, got.y, got.z);
          end
        end
      end
    end
  end

  // output back-pressure: a fresh stall is drawn after every item taken
  always @(posedge clk) begin
    int hold;
    if (pos_out.valid && pos_out.ready) begin
      hold = recv_free ? 0 : $urandom_range(0, 17);
      stall_left <= hold;
      pos_out.ready <= (hold == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pos_out.ready <= (stall_left == 1);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = send_free ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      pos_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pos_in.valid <= 1'b1;
    pos_in.pos_x <= x;
    pos_in.pos_y <= y;
    pos_in.pos_z <= z;
    do @(posedge clk); while (!pos_in.ready);
  endtask

  task automatic wait_drain();
    pos_in.valid <= 1'b0;
    while (expected_pos.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MAG) mag_num = val[3:0];
    else step_dt = val[16:0];
  endtask

  task automatic set_flow(logic [3:0] m, logic [16:0] dt);
    wait_drain();
    write_reg(REG_MAG, {28'd0, m});
    write_reg(REG_DT, {15'd0, dt});
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      default: return 32'($signed($urandom_range(0, 32)) - 16);
    endcase
  endfunction

  task automatic test_directed();
    send_pos(32'd0, 32'd0, 32'h7fffffff);
    send_pos(32'd1, 32'hffffffff, 32'h80000000);
    // axis cut boundary: 6^2+1^2 inside, 6^2+3^2 outside
    send_pos(32'd6, 32'd1, 32'd0);
    send_pos(32'd6, 32'd3, 32'd0);
    send_pos(32'd65536, 32'd0, 32'hffffffff);
    send_pos(32'd0, -32'sd65536, 32'd1);
    send_pos(32'h7fffffff, 32'h7fffffff, 32'd5);
    send_pos(32'h80000000, 32'h80000000, 32'd5);
    send_pos(32'h80000000, 32'h7fffffff, 32'd5);
    send_pos(32'h7fffffff, 32'h80000000, 32'd5);
    send_pos(32'd7, 32'd0, 32'd0);
    send_pos(32'd0, -32'sd7, 32'd0);
    send_pos(32'd1, 32'd0, 32'd0);
    send_pos(32'h00010000, 32'h00010000, 32'h12345678);
    send_pos(32'hffff0000, 32'h00008000, 32'hedcba987);
  endtask

  task automatic test_config_sweep();
    logic [3:0]  mags[7] = '{4'd8, 4'd9, 4'd7, 4'd0, 4'd15, 4'd3, 4'd1};
    logic [16:0] dts[7]  = '{17'd131071, 17'd65536, 17'd0, 17'd1, 17'd6554, 17'd32768, 17'd6554};
    for (int p = 0; p < 7; p++) begin
      set_flow(mags[p], dts[p]);
      for (int i = 0; i < 40; i++) send_pos(pick_coord(), pick_coord(), $urandom);
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < 560; i++) begin
      if (i % 80 == 0) begin
        send_free = ($urandom_range(0, 3) == 0);
        recv_free = ($urandom_range(0, 3) == 0);
      end
      send_pos(pick_coord(), pick_coord(), $urandom);
    end
    send_free = 1'b0;
    recv_free = 1'b0;
  endtask

  task automatic test_drain_restart();
    for (int i = 0; i < 20; i++) send_pos(pick_coord(), pick_coord(), $urandom);
    // sender holds off until the pipeline is empty
    wait_drain();
    set_flow(4'($urandom_range(0, 15)), 17'($urandom_range(0, 131071)));
    send_free = 1'b1;
    for (int i = 0; i < 40; i++) send_pos(pick_coord(), pick_coord(), $urandom);
    send_free = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pos_in.valid = 1'b0;
    pos_in.pos_x = '0;
    pos_in.pos_y = '0;
    pos_in.pos_z = '0;
    pos_out.ready = 1'b1;
    mag_num = MAG_RST;
    step_dt = DT_RST;
    mismatches = 0;
    cycles = 0;
    stall_left = 0;
    send_free = 1'b0;
    recv_free = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_sweep();
    test_drain_restart();
    set_flow(4'd1, 17'd6554);
    test_random();

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_pos.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
